### hdl/hkrb_pkg.sv
package hkrb_pkg;

    // slot counts: MAX_SLOTS is the report layout, USED_SLOTS the live part of it
    localparam int MAX_SLOTS  = 6;
    localparam int KEY_SLOTS  = 6;
    localparam int USED_SLOTS = (KEY_SLOTS > MAX_SLOTS) ? MAX_SLOTS :
                                ((KEY_SLOTS < 1) ? 1 : KEY_SLOTS);

    // modifier usages 224..231 share this upper code pattern
    localparam logic [4:0] MOD_PREFIX = 5'b11100;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FAIL = 1'b1;

    // one key event request
    typedef struct packed {
        logic [7:0] key_code;
        logic       pressed;
    } hkrb_event_t;

    // one report request
    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] slot_key_0;
        logic [7:0] slot_key_1;
        logic [7:0] slot_key_2;
        logic [7:0] slot_key_3;
        logic [7:0] slot_key_4;
        logic [7:0] slot_key_5;
        logic       status;
        logic       send_report;
    } hkrb_report_t;

    // event broadcast to every cell
    typedef struct packed {
        logic       en;
        logic       pressed;
        logic [7:0] key_code;
    } hkrb_ctrl_t;

    // flags handed from one cell to the next
    typedef struct packed {
        logic search;
        logic shift;
    } hkrb_link_t;

endpackage

### hdl/hid_keyboard_report_builder_unit.sv
// Boot keyboard report builder, six-key rollover. Each key event request
// updates the held-modifier byte or the row of key slots and returns one
// report request with the full report after the update, a status and a send
// flag. One event is taken every cycle while not stalled; its report appears
// in the cycle after acceptance from the output register, and a new event is
// taken in the same cycle the waiting report is taken. The figure is set by
// the row of slot cells, which finds the slot and compacts the row through a
// chain of neighbor flags. Reset empties every slot and clears modifiers.
module hid_keyboard_report_builder_unit
    import hkrb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         key_valid,
    output logic         key_ready,
    input  hkrb_event_t  key_event,
    output logic         report_valid,
    input  logic         report_ready,
    output hkrb_report_t report
);

    logic         accept;
    logic         is_mod;
    logic [7:0]   mod_bit;
    logic [7:0]   modifier_reg;
    logic [7:0]   modifier_next;
    logic         ok;
    logic         gap_seen;
    logic         report_valid_reg;
    hkrb_report_t report_reg;
    hkrb_report_t report_next;
    hkrb_ctrl_t   ctrl;

    hkrb_link_t   link [USED_SLOTS:0];
    logic [7:0]   cur_val  [MAX_SLOTS];
    logic [7:0]   next_val [MAX_SLOTS];
    logic         moves    [USED_SLOTS:0];
    logic [7:0]   chain_val[USED_SLOTS:0];

    // handshake
    assign key_ready    = !report_valid_reg || report_ready;
    assign accept       = key_valid && key_ready;
    assign report_valid = report_valid_reg;
    assign report       = report_reg;

    // event decode
    assign is_mod  = (key_event.key_code[7:3] == MOD_PREFIX);
    assign mod_bit = 8'b1 << key_event.key_code[2:0];

    assign ctrl.en       = accept && !is_mod;
    assign ctrl.pressed  = key_event.pressed;
    assign ctrl.key_code = key_event.key_code;

    // chain ends
    assign link[0].search       = 1'b1;
    assign link[0].shift        = 1'b0;
    assign moves[USED_SLOTS]    = 1'b0;
    assign chain_val[USED_SLOTS] = 8'd0;

    // row of slot cells
    genvar g;
    generate
        for (g = 0; g < MAX_SLOTS; g++)
        begin : g_slot
            if (g < USED_SLOTS)
            begin : g_used
                hkrb_key_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (ctrl),
                    .link_in    (link[g]),
                    .link_out   (link[g+1]),
                    .right_val  (chain_val[g+1]),
                    .right_moves(moves[g+1]),
                    .val        (cur_val[g]),
                    .moves_left (moves[g]),
                    .val_next   (next_val[g])
                );
                assign chain_val[g] = cur_val[g];
            end
            else
            begin : g_unused
                assign cur_val[g]  = 8'd0;
                assign next_val[g] = 8'd0;
            end
        end
    endgenerate

    // modifier byte and outcome
    always_comb
    begin
        if (key_event.pressed)
        begin
            modifier_next = modifier_reg | mod_bit;
        end
        else
        begin
            modifier_next = modifier_reg & ~mod_bit;
        end
        ok = is_mod || !link[USED_SLOTS].search;
    end

    // report assembly
    always_comb
    begin
        report_next.modifier_bits = is_mod ? modifier_next : modifier_reg;
        report_next.slot_key_0    = is_mod ? cur_val[0] : next_val[0];
        report_next.slot_key_1    = is_mod ? cur_val[1] : next_val[1];
        report_next.slot_key_2    = is_mod ? cur_val[2] : next_val[2];
        report_next.slot_key_3    = is_mod ? cur_val[3] : next_val[3];
        report_next.slot_key_4    = is_mod ? cur_val[4] : next_val[4];
        report_next.slot_key_5    = is_mod ? cur_val[5] : next_val[5];
        report_next.status        = ok ? STATUS_OK : STATUS_FAIL;
        report_next.send_report   = ok;
    end

    // modifier register and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modifier_reg     <= 8'd0;
            report_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept && is_mod)
            begin
                modifier_reg <= modifier_next;
            end
            if (accept)
            begin
                report_valid_reg <= 1'b1;
            end
            else if (report_ready)
            begin
                report_valid_reg <= 1'b0;
            end
        end
    end

    // report payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            report_reg <= report_next;
        end
    end

    // packed-row check: a held key never sits after an empty slot
    always_comb
    begin
        gap_seen = 1'b0;
        for (int i = 1; i < MAX_SLOTS; i++)
        begin
            if ((cur_val[i-1] == 8'd0) && (cur_val[i] != 8'd0))
            begin
                gap_seen = 1'b1;
            end
        end
    end

    // checks
    a_row_packed: assert property (@(posedge clk) disable iff (!rst_n)
        !gap_seen)
        else $error("key row has a held key after an empty slot");

    a_report_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> report_valid_reg)
        else $error("accepted event gave no report");

    a_mod_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_mod) |=> (report_reg.status == STATUS_OK))
        else $error("modifier event reported failure");

    a_flag_pair: assert property (@(posedge clk) disable iff (!rst_n)
        report_valid_reg |-> (report_reg.send_report == (report_reg.status == STATUS_OK)))
        else $error("send flag disagrees with status");

endmodule

### hdl/hkrb_key_cell.sv
module hkrb_key_cell
    import hkrb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  hkrb_ctrl_t ctrl,
    input  hkrb_link_t link_in,
    output hkrb_link_t link_out,
    input  logic [7:0] right_val,
    input  logic       right_moves,
    output logic [7:0] val,
    output logic       moves_left,
    output logic [7:0] val_next
);

    logic [7:0] slot_reg;
    logic [7:0] slot_next;
    logic [7:0] target;
    logic       hit;
    logic       occupied;

    // press looks for an empty slot, release for the matching code
    always_comb
    begin
        target     = ctrl.pressed ? 8'd0 : ctrl.key_code;
        hit        = link_in.search && (slot_reg == target);
        occupied   = (slot_reg != 8'd0);
        moves_left = !ctrl.pressed && link_in.shift && occupied;

        link_out.search = link_in.search && !hit;
        link_out.shift  = !ctrl.pressed && (hit || moves_left);

        slot_next = slot_reg;
        if (ctrl.pressed)
        begin
            if (hit)
            begin
                slot_next = ctrl.key_code;
            end
        end
        else if (hit || moves_left)
        begin
            // vacated: take the right neighbor if it slides in, else empty
            slot_next = right_moves ? right_val : 8'd0;
        end
    end

    // slot storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg <= 8'd0;
        end
        else if (ctrl.en)
        begin
            slot_reg <= slot_next;
        end
    end

    assign val      = slot_reg;
    assign val_next = slot_next;

endmodule
